// ----- rtl/rfhp_pkg.sv -----
`default_nettype none

package rfhp_pkg;

    // Longest callsign kept, in characters
    localparam int unsigned MAX_CALL_CHARS = 8;
    localparam int unsigned CALL_BYTES     = 8;

    // Configuration register indexes
    localparam logic [1:0] CFG_FUTURE_DELIM   = 2'd0;
    localparam logic [1:0] CFG_PAST_DELIM     = 2'd1;
    localparam logic [1:0] CFG_INTERNET_DELIM = 2'd2;

    // Delimiter reset values
    localparam logic [7:0] FUTURE_DELIM_RST   = 8'd253;
    localparam logic [7:0] PAST_DELIM_RST     = 8'd255;
    localparam logic [7:0] INTERNET_DELIM_RST = 8'd254;

    typedef enum logic [1:0] {
        PHASE_NAME     = 2'd0,
        PHASE_SSID     = 2'd1,
        PHASE_STRENGTH = 2'd2
    } parse_phase_t;

    typedef enum logic [1:0] {
        HOP_FUTURE = 2'd0,
        HOP_PAST   = 2'd1,
        HOP_INET   = 2'd2
    } hop_kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_route;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  hop_kind;
        logic [63:0] callsign_packed;
        logic [3:0]  callsign_length;
        logic        callsign_truncated;
        logic [7:0]  hop_ssid;
        logic [7:0]  strength_code;
        logic [7:0]  hop_number;
        logic [7:0]  digipeat_limit;
    } out_item_t;

    typedef struct packed {
        logic [7:0] future_delim;
        logic [7:0] past_delim;
        logic [7:0] internet_delim;
    } delim_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/rfhp_parse.sv -----
`default_nettype none

module rfhp_parse (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_fire,
    input  wire rfhp_pkg::in_item_t   in_item,
    input  wire rfhp_pkg::delim_cfg_t delim,
    output logic                      res_valid,
    output rfhp_pkg::out_item_t       res_item
);
    import rfhp_pkg::*;

    parse_phase_t phase_reg, phase_next;
    logic [7:0]   limit_reg, limit_next;
    logic [63:0]  name_reg, name_next;
    logic [3:0]   count_reg, count_next;
    logic         overflow_reg, overflow_next;
    hop_kind_t    pkind_reg, pkind_next;
    logic [7:0]   pssid_reg, pssid_next;
    logic [7:0]   hops_reg, hops_next;

    logic [7:0] b;
    logic       is_inet, is_past, is_future;
    logic       emit;
    hop_kind_t  emit_kind;
    logic [7:0] emit_ssid, emit_strength;

    assign b         = in_item.data_byte;
    assign is_inet   = (b == delim.internet_delim);
    assign is_past   = (b == delim.past_delim);
    assign is_future = (b == delim.future_delim);

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        if (in_fire) begin
            if (in_item.start_of_route) begin
                phase_next = PHASE_NAME;
            end else begin
                case (phase_reg)
                    PHASE_SSID: begin
                        phase_next = (pkind_reg == HOP_PAST) ? PHASE_STRENGTH : PHASE_NAME;
                    end
                    PHASE_STRENGTH: begin
                        phase_next = PHASE_NAME;
                    end
                    default: begin
                        if (is_inet) begin
                            phase_next = PHASE_NAME;
                        end else if (is_past || is_future) begin
                            phase_next = PHASE_SSID;
                        end else begin
                            phase_next = PHASE_NAME;
                        end
                    end
                endcase
            end
        end
    end

    // Hop completion and field collection
    always_comb begin
        emit          = 1'b0;
        emit_kind     = HOP_FUTURE;
        emit_ssid     = 8'd0;
        emit_strength = 8'd0;
        limit_next    = limit_reg;
        name_next     = name_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        pkind_next    = pkind_reg;
        pssid_next    = pssid_reg;
        hops_next     = hops_reg;
        if (in_fire) begin
            if (in_item.start_of_route) begin
                limit_next    = b;
                hops_next     = 8'd0;
                name_next     = 64'd0;
                count_next    = 4'd0;
                overflow_next = 1'b0;
                pkind_next    = HOP_FUTURE;
                pssid_next    = 8'd0;
            end else begin
                case (phase_reg)
                    PHASE_SSID: begin
                        if (pkind_reg == HOP_PAST) begin
                            pssid_next = b;
                        end else begin
                            emit      = 1'b1;
                            emit_kind = HOP_FUTURE;
                            emit_ssid = b;
                        end
                    end
                    PHASE_STRENGTH: begin
                        emit          = 1'b1;
                        emit_kind     = HOP_PAST;
                        emit_ssid     = pssid_reg;
                        emit_strength = b;
                    end
                    default: begin
                        if (is_inet) begin
                            emit      = 1'b1;
                            emit_kind = HOP_INET;
                        end else if (is_past) begin
                            pkind_next = HOP_PAST;
                        end else if (is_future) begin
                            pkind_next = HOP_FUTURE;
                        end else if (count_reg < 4'(MAX_CALL_CHARS)) begin
                            // Drop the byte into the lane at the fill count
                            for (int i = 0; i < CALL_BYTES; i++) begin
                                if (count_reg == 4'(i)) begin
                                    name_next[8*i +: 8] = b;
                                end
                            end
                            count_next = count_reg + 4'd1;
                        end else begin
                            overflow_next = 1'b1;
                        end
                    end
                endcase
                if (emit) begin
                    hops_next     = hops_reg + 8'd1;
                    name_next     = 64'd0;
                    count_next    = 4'd0;
                    overflow_next = 1'b0;
                end
            end
        end
    end

    // Result item, taken by the output stage on the same edge
    always_comb begin
        res_valid                   = emit;
        res_item.hop_kind           = emit_kind;
        res_item.callsign_packed    = (emit_kind == HOP_INET) ? 64'd0 : name_reg;
        res_item.callsign_length    = (emit_kind == HOP_INET) ? 4'd0 : count_reg;
        res_item.callsign_truncated = (emit_kind == HOP_INET) ? 1'b0 : overflow_reg;
        res_item.hop_ssid           = emit_ssid;
        res_item.strength_code      = emit_strength;
        res_item.hop_number         = hops_reg;
        res_item.digipeat_limit     = limit_reg;
    end

    // Parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PHASE_NAME;
            limit_reg    <= 8'd0;
            name_reg     <= 64'd0;
            count_reg    <= 4'd0;
            overflow_reg <= 1'b0;
            pkind_reg    <= HOP_FUTURE;
            pssid_reg    <= 8'd0;
            hops_reg     <= 8'd0;
        end else begin
            phase_reg    <= phase_next;
            limit_reg    <= limit_next;
            name_reg     <= name_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            pkind_reg    <= pkind_next;
            pssid_reg    <= pssid_next;
            hops_reg     <= hops_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rfhp_out_buf.sv -----
`default_nettype none

module rfhp_out_buf (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    input  wire rfhp_pkg::out_item_t in_item,
    output logic                     in_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output rfhp_pkg::out_item_t      m_item
);
    import rfhp_pkg::*;

    logic      main_valid_reg;
    out_item_t main_reg;
    logic      skid_valid_reg;
    out_item_t skid_reg;
    logic      main_free;

    assign in_ready  = !skid_valid_reg;
    assign m_valid   = main_valid_reg;
    assign m_item    = main_reg;
    assign main_free = !main_valid_reg || m_ready;

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (main_free) begin
            main_valid_reg <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Hold results; the skid stage catches a transfer while the output stalls
    always_ff @(posedge aclk) begin
        if (main_free) begin
            main_reg <= skid_valid_reg ? skid_reg : in_item;
        end else if (in_valid && !skid_valid_reg) begin
            skid_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/route_field_hop_parser.sv -----
`default_nettype none
// A completed hop's result goes through the output register (or skid register) to m_valid.
// Throughput: one byte per cycle while s_ready is high; each byte updates the parse state once.
// The output stage and its skid register hold up to two results before s_ready drops.
// Reset (aresetn low, synchronous): parse state and hop count clear, no result pending,
// and the delimiters return to 253 (future), 255 (past) and 254 (internet).

module route_field_hop_parser (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [7:0]          cfg_wr_data,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire rfhp_pkg::in_item_t  s_payload,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output rfhp_pkg::out_item_t      m_payload
);
    import rfhp_pkg::*;

    delim_cfg_t delim_reg;
    logic       s_fire;
    logic       res_valid;
    out_item_t  res_item;

    assign s_fire = s_valid && s_ready;

    // Delimiter registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg.future_delim   <= FUTURE_DELIM_RST;
            delim_reg.past_delim     <= PAST_DELIM_RST;
            delim_reg.internet_delim <= INTERNET_DELIM_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FUTURE_DELIM:   delim_reg.future_delim   <= cfg_wr_data;
                CFG_PAST_DELIM:     delim_reg.past_delim     <= cfg_wr_data;
                CFG_INTERNET_DELIM: delim_reg.internet_delim <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    rfhp_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (s_fire),
        .in_item   (s_payload),
        .delim     (delim_reg),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    rfhp_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (res_valid),
        .in_item  (res_item),
        .in_ready (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_payload)
    );

    // A start byte never completes a hop
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_fire && s_payload.start_of_route && res_valid))
        else $error("start byte produced a hop");

    // An internet hop carries no callsign
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_item.hop_kind == HOP_INET) |->
            (res_item.callsign_length == 4'd0 && res_item.callsign_packed == 64'd0))
        else $error("internet hop with callsign");

    // Input stalls only while a result waits at the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty output");

    // No result right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present after reset");

endmodule

`default_nettype wire
